FILE: rtl/cmbb_pkg.sv
// Shared types and constants for the color marker bounding box block.
// No dependencies; imported by every module of the block.
package cmbb_pkg;

  localparam int CHAN_W      = 8;
  localparam int TOL_W       = 9;
  localparam int PROX_W      = 11;
  localparam int MARGIN_W    = 10;
  localparam int DIM_W       = 11;
  localparam int COLOR_W     = 24;
  localparam int EDGE_W      = 11;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // configuration register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TOLERANCE    = 3'd0,
    REG_PROXIMITY    = 3'd1,
    REG_TOP_MARGIN   = 3'd2,
    REG_BOTTOM_MARGIN = 3'd3,
    REG_FRAME_WIDTH  = 3'd4,
    REG_FRAME_HEIGHT = 3'd5,
    REG_PRIMARY      = 3'd6,
    REG_SECONDARY    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [TOL_W-1:0]    tolerance;
    logic [PROX_W-1:0]   proximity;
    logic [MARGIN_W-1:0] top_margin;
    logic [MARGIN_W-1:0] bottom_margin;
    logic [DIM_W-1:0]    frame_width;
    logic [DIM_W-1:0]    frame_height;
    logic [COLOR_W-1:0]  primary;
    logic [COLOR_W-1:0]  secondary;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tolerance:     9'd90,
    proximity:     11'd120,
    top_margin:    10'd80,
    bottom_margin: 10'd80,
    frame_width:   11'd640,
    frame_height:  11'd480,
    primary:       24'h00FF00,
    secondary:     24'h0000FF
  };

  // per-pixel control flags carried through the queue
  typedef struct packed {
    logic first;    // clear trackers before this pixel
    logic last;     // result follows this pixel
    logic row_end;  // row advances after this pixel
  } pix_flags_t;

  function automatic logic [CHAN_W-1:0] chan_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    chan_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: rtl/cmbb_front.sv
// Front end: raster counters, color match and row window per pixel.
// Depends on cmbb_pkg.
module cmbb_front import cmbb_pkg::*; #(
  parameter int MAX_COLUMNS   = 1024,
  parameter int MAX_ROWS      = 1024,
  parameter int TARGET_COLORS = 2,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     accept,
  input  logic [CHAN_W-1:0]        pixel_red,
  input  logic [CHAN_W-1:0]        pixel_green,
  input  logic [CHAN_W-1:0]        pixel_blue,
  input  logic                     first_of_frame,
  input  logic                     last_of_frame,
  output logic [CW-1:0]            pix_x,
  output logic [RW-1:0]            pix_y,
  output logic [TARGET_COLORS-1:0] pix_hit,
  output pix_flags_t               pix_flags
);

  localparam int CMPW = ((CW > DIM_W) ? CW : DIM_W) + 1;
  localparam int RWW  = ((RW > DIM_W) ? RW : DIM_W) + 1;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [CMPW-1:0] col_inc;
  logic row_end;
  logic in_window;
  logic [TARGET_COLORS-1:0] color_match;
  logic [COLOR_W-1:0] target [TARGET_COLORS];

  assign col_cur = first_of_frame ? '0 : col;
  assign row_cur = first_of_frame ? '0 : row;
  assign col_inc = CMPW'(col_cur) + CMPW'(1);
  assign row_end = (col_inc >= CMPW'(cfg.frame_width)) || (col_inc >= CMPW'(MAX_COLUMNS));

  assign in_window = (RWW'(row_cur) >= RWW'(cfg.top_margin)) &&
                     ((RWW'(row_cur) + RWW'(cfg.bottom_margin)) < RWW'(cfg.frame_height));

  always_comb begin
    for (int k = 0; k < TARGET_COLORS; k++) begin
      target[k] = (k == 0) ? cfg.primary : cfg.secondary;
      color_match[k] =
        ({1'b0, chan_diff(target[k][23:16], pixel_red)}  < cfg.tolerance) &&
        ({1'b0, chan_diff(target[k][15:8],  pixel_green)} < cfg.tolerance) &&
        ({1'b0, chan_diff(target[k][7:0],   pixel_blue)}  < cfg.tolerance);
    end
  end

  assign pix_x     = col_cur;
  assign pix_y     = row_cur;
  assign pix_hit   = in_window ? color_match : '0;
  assign pix_flags = '{first: first_of_frame, last: last_of_frame, row_end: row_end};

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (row_end) begin
        col <= '0;
        row <= (row_cur == RW'(MAX_ROWS - 1)) ? '0 : row_cur + RW'(1);
      end else begin
        col <= col_inc[CW-1:0];
        row <= row_cur;
      end
    end
  end

endmodule

FILE: rtl/cmbb_queue.sv
// Two-entry word queue between the front and back ends.
// Depends on cmbb_pkg only by convention; payload is a flat vector.
module cmbb_queue import cmbb_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             can_push,
  input  logic             pop,
  output logic             has_data,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign can_push = (count != 2'd2);
  assign has_data = (count != 2'd0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/cmbb_back.sv
// Back end: per-color box trackers and the registered result word.
// Depends on cmbb_pkg.
module cmbb_back import cmbb_pkg::*; #(
  parameter int MAX_COLUMNS   = 1024,
  parameter int MAX_ROWS      = 1024,
  parameter int TARGET_COLORS = 2,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  logic [CW-1:0]            q_x,
  input  logic [RW-1:0]            q_y,
  input  logic [TARGET_COLORS-1:0] q_hit,
  input  pix_flags_t               q_flags,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     marker_found,
  output logic                     found_color,
  output logic [EDGE_W-1:0]        left_edge,
  output logic [EDGE_W-1:0]        right_edge,
  output logic [EDGE_W-1:0]        top_edge,
  output logic [EDGE_W-1:0]        bottom_edge
);

  localparam int BW0 = (CW > DIM_W) ? CW : DIM_W;
  localparam int BW  = (RW > BW0) ? RW : BW0;
  localparam int SW  = BW + 1;

  logic          found  [TARGET_COLORS];
  logic [BW-1:0] left   [TARGET_COLORS];
  logic [BW-1:0] right  [TARGET_COLORS];
  logic [BW-1:0] top    [TARGET_COLORS];
  logic [BW-1:0] bottom [TARGET_COLORS];
  logic          halted [TARGET_COLORS];

  logic          found_c  [TARGET_COLORS];
  logic [BW-1:0] left_c   [TARGET_COLORS];
  logic [BW-1:0] right_c  [TARGET_COLORS];
  logic [BW-1:0] top_c    [TARGET_COLORS];
  logic [BW-1:0] bottom_c [TARGET_COLORS];
  logic          halted_c [TARGET_COLORS];

  logic          found_n  [TARGET_COLORS];
  logic [BW-1:0] left_n   [TARGET_COLORS];
  logic [BW-1:0] right_n  [TARGET_COLORS];
  logic [BW-1:0] top_n    [TARGET_COLORS];
  logic [BW-1:0] bottom_n [TARGET_COLORS];
  logic          halted_n [TARGET_COLORS];

  logic [TARGET_COLORS-1:0] upd_left;
  logic [TARGET_COLORS-1:0] upd_top;
  logic [TARGET_COLORS-1:0] grow;

  logic [BW-1:0] x_b;
  logic [BW-1:0] y_b;
  logic [SW-1:0] prox;

  logic              res_found;
  logic              res_color;
  logic [EDGE_W-1:0] res_left;
  logic [EDGE_W-1:0] res_right;
  logic [EDGE_W-1:0] res_top;
  logic [EDGE_W-1:0] res_bottom;

  assign x_b   = BW'(q_x);
  assign y_b   = BW'(q_y);
  assign prox  = SW'(cfg.proximity);
  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    for (int k = 0; k < TARGET_COLORS; k++) begin
      // frame start clears with the current frame size
      found_c[k]  = q_flags.first ? 1'b0 : found[k];
      left_c[k]   = q_flags.first ? BW'(cfg.frame_width) : left[k];
      right_c[k]  = q_flags.first ? '0 : right[k];
      top_c[k]    = q_flags.first ? BW'(cfg.frame_height) : top[k];
      bottom_c[k] = q_flags.first ? '0 : bottom[k];
      halted_c[k] = q_flags.first ? 1'b0 : halted[k];

      upd_left[k] = (x_b < left_c[k]) && (SW'(left_c[k] - x_b) < prox);
      upd_top[k]  = (y_b < top_c[k]) && (SW'(top_c[k] - y_b) < prox);
      // a lowered edge always passes its own proximity test
      grow[k] = (upd_left[k] || (SW'(x_b) < SW'(left_c[k]) + prox)) &&
                (upd_top[k]  || (SW'(y_b) < SW'(top_c[k]) + prox));

      found_n[k]  = found_c[k];
      left_n[k]   = left_c[k];
      right_n[k]  = right_c[k];
      top_n[k]    = top_c[k];
      bottom_n[k] = bottom_c[k];
      halted_n[k] = halted_c[k];

      if (q_hit[k] && !halted_c[k]) begin
        if (!found_c[k]) begin
          found_n[k] = 1'b1;
          if (x_b < left_c[k])   left_n[k]   = x_b;
          if (x_b > right_c[k])  right_n[k]  = x_b;
          if (y_b < top_c[k])    top_n[k]    = y_b;
          if (y_b > bottom_c[k]) bottom_n[k] = y_b;
        end else begin
          if (upd_left[k]) left_n[k] = x_b;
          if (upd_top[k])  top_n[k]  = y_b;
          if (grow[k]) begin
            if (x_b > right_c[k])  right_n[k]  = x_b;
            if (y_b > bottom_c[k]) bottom_n[k] = y_b;
          end else begin
            halted_n[k] = 1'b1;
          end
        end
      end
      if (q_flags.row_end) halted_n[k] = 1'b0;
    end
  end

  // lowest color index that has a box wins
  always_comb begin
    res_found  = 1'b0;
    res_color  = 1'b0;
    res_left   = '0;
    res_right  = '0;
    res_top    = '0;
    res_bottom = '0;
    for (int k = TARGET_COLORS - 1; k >= 0; k--) begin
      if (found_n[k]) begin
        res_found  = 1'b1;
        res_color  = (k % 2) == 1;
        res_left   = left_n[k][EDGE_W-1:0];
        res_right  = right_n[k][EDGE_W-1:0];
        res_top    = top_n[k][EDGE_W-1:0];
        res_bottom = bottom_n[k][EDGE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int k = 0; k < TARGET_COLORS; k++) begin
        found[k]  <= 1'b0;
        left[k]   <= BW'(CFG_RESET.frame_width);
        right[k]  <= '0;
        top[k]    <= BW'(CFG_RESET.frame_height);
        bottom[k] <= '0;
        halted[k] <= 1'b0;
      end
    end else begin
      if (q_pop) begin
        for (int k = 0; k < TARGET_COLORS; k++) begin
          found[k]  <= found_n[k];
          left[k]   <= left_n[k];
          right[k]  <= right_n[k];
          top[k]    <= top_n[k];
          bottom[k] <= bottom_n[k];
          halted[k] <= halted_n[k];
        end
      end
      if (q_pop && q_flags.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_flags.last) begin
      marker_found <= res_found;
      found_color  <= res_color;
      left_edge    <= res_left;
      right_edge   <= res_right;
      top_edge     <= res_top;
      bottom_edge  <= res_bottom;
    end
  end

endmodule

FILE: rtl/color_marker_bounding_box.sv
// Color marker bounding box: top level with config registers and assertions.
// Depends on cmbb_pkg, cmbb_front, cmbb_queue and cmbb_back.
//
// Usage:
//   Pixels enter on the in_valid/in_ready channel in raster order, one word
//   per pixel. first_of_frame clears the column/row counters and both box
//   trackers before its pixel; last_of_frame makes the block emit one
//   result word on out_valid/out_ready after that pixel is tracked.
//   Configuration is a plain write port (cfg_write_enable, cfg_index,
//   cfg_data); write only while no pixel is in flight.
// Throughput: one pixel per cycle unless a result word waits. The front end
//   classifies a pixel in the accept cycle; the back end updates the trackers
//   one pixel per cycle, bound by the single tracker update per color.
// Result path: a last pixel is accepted into the queue, then its tracker
//   update loads the output register that drives the result word.
// Stall: while a result word waits, the back end holds and the 2-word
//   queue keeps taking pixels until full; in_ready then drops.
// Reset: rst clears counters, queue and trackers, and loads the config
//   registers with their defaults (640x480 frame, green/blue targets).
module color_marker_bounding_box import cmbb_pkg::*; #(
  parameter int MAX_COLUMNS   = 1024,
  parameter int MAX_ROWS      = 1024,
  parameter int TARGET_COLORS = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_write_enable,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // pixel channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CHAN_W-1:0]      pixel_red,
  input  logic [CHAN_W-1:0]      pixel_green,
  input  logic [CHAN_W-1:0]      pixel_blue,
  input  logic                   first_of_frame,
  input  logic                   last_of_frame,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   marker_found,
  output logic                   found_color,
  output logic [EDGE_W-1:0]      left_edge,
  output logic [EDGE_W-1:0]      right_edge,
  output logic [EDGE_W-1:0]      top_edge,
  output logic [EDGE_W-1:0]      bottom_edge
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int FLAG_W = $bits(pix_flags_t);
  localparam int QW = TARGET_COLORS + RW + CW + FLAG_W;

  cfg_t cfg;

  logic                     accept;
  logic [CW-1:0]            f_x;
  logic [RW-1:0]            f_y;
  logic [TARGET_COLORS-1:0] f_hit;
  pix_flags_t               f_flags;

  logic                     q_valid;
  logic                     q_pop;
  logic [QW-1:0]            q_word;
  logic [CW-1:0]            q_x;
  logic [RW-1:0]            q_y;
  logic [TARGET_COLORS-1:0] q_hit;
  pix_flags_t               q_flags;

  assign accept = in_valid && in_ready;

  // Config registers: written any cycle the enable is high, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_reg_t'(cfg_index))
        REG_TOLERANCE:     cfg.tolerance     <= cfg_data[TOL_W-1:0];
        REG_PROXIMITY:     cfg.proximity     <= cfg_data[PROX_W-1:0];
        REG_TOP_MARGIN:    cfg.top_margin    <= cfg_data[MARGIN_W-1:0];
        REG_BOTTOM_MARGIN: cfg.bottom_margin <= cfg_data[MARGIN_W-1:0];
        REG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data[DIM_W-1:0];
        REG_PRIMARY:       cfg.primary       <= cfg_data[COLOR_W-1:0];
        REG_SECONDARY:     cfg.secondary     <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: counts raster position and tags each pixel with per-color hits.
  cmbb_front #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_ROWS     (MAX_ROWS),
    .TARGET_COLORS(TARGET_COLORS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (accept),
    .pixel_red     (pixel_red),
    .pixel_green   (pixel_green),
    .pixel_blue    (pixel_blue),
    .first_of_frame(first_of_frame),
    .last_of_frame (last_of_frame),
    .pix_x         (f_x),
    .pix_y         (f_y),
    .pix_hit       (f_hit),
    .pix_flags     (f_flags)
  );

  // Queue decouples pixel intake from tracker updates / result stalls.
  cmbb_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data({f_hit, f_y, f_x, f_flags}),
    .can_push (in_ready),
    .pop      (q_pop),
    .has_data (q_valid),
    .pop_data (q_word)
  );

  assign {q_hit, q_y, q_x, q_flags} = q_word;

  // Back: box trackers and the result register.
  cmbb_back #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_ROWS     (MAX_ROWS),
    .TARGET_COLORS(TARGET_COLORS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_x         (q_x),
    .q_y         (q_y),
    .q_hit       (q_hit),
    .q_flags     (q_flags),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .marker_found(marker_found),
    .found_color (found_color),
    .left_edge   (left_edge),
    .right_edge  (right_edge),
    .top_edge    (top_edge),
    .bottom_edge (bottom_edge)
  );

  // A full queue must have something to drain.
  a_full_has_data: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("queue full but empty");

  // A new result only follows a last-of-frame word leaving the queue.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(q_pop && q_flags.last))
    else $error("result without last pixel");

  // No marker means an all-zero box.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !marker_found) |->
      (!found_color && left_edge == '0 && right_edge == '0 &&
       top_edge == '0 && bottom_edge == '0))
    else $error("empty result carries a box");

  // The back end never pops while a result is stuck.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !q_pop)
    else $error("tracker advanced during output stall");

endmodule

FILE: test/cmbb_box_checker.sv
`timescale 1ns / 1ps
// Scoreboard for color_marker_bounding_box: mirrors the config registers, tracks
// both color boxes per accepted pixel word and checks every result word.
// Depends on cmbb_pkg.
module cmbb_box_checker import cmbb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_enable,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [CHAN_W-1:0]      pixel_red,
  input  logic [CHAN_W-1:0]      pixel_green,
  input  logic [CHAN_W-1:0]      pixel_blue,
  input  logic                   first_of_frame,
  input  logic                   last_of_frame,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   marker_found,
  input  logic                   found_color,
  input  logic [EDGE_W-1:0]      left_edge,
  input  logic [EDGE_W-1:0]      right_edge,
  input  logic [EDGE_W-1:0]      top_edge,
  input  logic [EDGE_W-1:0]      bottom_edge,
  output int                     mismatches,
  output int                     outstanding
);

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  typedef struct {
    logic              found;
    logic              color;
    logic [EDGE_W-1:0] lft;
    logic [EDGE_W-1:0] rgt;
    logic [EDGE_W-1:0] tp;
    logic [EDGE_W-1:0] btm;
  } box_report_t;

  box_report_t expected_boxes[$];

  // register mirror
  int                 tol, prox, top_rows, bottom_rows, f_width, f_height;
  logic [COLOR_W-1:0] color_a, color_b;

  // tracker state
  bit seen [2];
  bit halted [2];
  int box_l [2], box_r [2], box_t [2], box_b [2];
  int col, row;

  function automatic int gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit color_hit(logic [COLOR_W-1:0] tgt, logic [CHAN_W-1:0] r,
                                   logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
    return gap(int'(tgt[23:16]), int'(r)) < tol && gap(int'(tgt[15:8]), int'(g)) < tol &&
           gap(int'(tgt[7:0]), int'(b)) < tol;
  endfunction

  task automatic clear_boxes();
    for (int k = 0; k < 2; k++) begin
      seen[k]   = 1'b0;
      halted[k] = 1'b0;
      box_l[k]  = f_width;
      box_r[k]  = 0;
      box_t[k]  = f_height;
      box_b[k]  = 0;
    end
    col = 0;
    row = 0;
  endtask

  task automatic grow_box(int k, int x, int y);
    if (!seen[k]) begin
      seen[k] = 1'b1;
      if (x < box_l[k]) box_l[k] = x;
      if (x > box_r[k]) box_r[k] = x;
      if (y < box_t[k]) box_t[k] = y;
      if (y > box_b[k]) box_b[k] = y;
    end else begin
      if (gap(x, box_l[k]) < prox && x < box_l[k]) box_l[k] = x;
      if (gap(y, box_t[k]) < prox && y < box_t[k]) box_t[k] = y;
      if (x < box_l[k] + prox && y < box_t[k] + prox) begin
        if (x > box_r[k]) box_r[k] = x;
        if (y > box_b[k]) box_b[k] = y;
      end else begin
        halted[k] = 1'b1;
      end
    end
  endtask

  task automatic track_pixel();
    box_report_t rep;
    if (first_of_frame) clear_boxes();
    if (row >= top_rows && row + bottom_rows < f_height) begin
      for (int k = 0; k < 2; k++)
        if (!halted[k] && color_hit(k == 0 ? color_a : color_b, pixel_red, pixel_green,
                                    pixel_blue))
          grow_box(k, col, row);
    end
    if (col + 1 >= f_width || col + 1 >= MAX_COLUMNS) begin
      col = 0;
      row = (row + 1) % MAX_ROWS;
      halted[0] = 1'b0;
      halted[1] = 1'b0;
    end else begin
      col++;
    end
    if (last_of_frame) begin
      rep = '{1'b0, 1'b0, '0, '0, '0, '0};
      // primary wins when both colors were seen
      for (int k = 1; k >= 0; k--)
        if (seen[k])
          rep = '{1'b1, k[0], box_l[k][EDGE_W-1:0], box_r[k][EDGE_W-1:0],
                  box_t[k][EDGE_W-1:0], box_b[k][EDGE_W-1:0]};
      expected_boxes.push_back(rep);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("checker: %0t %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    box_report_t want;
    if (expected_boxes.size() == 0) begin
      report_mismatch("result word with none pending", 0, 0);
    end else begin
      want = expected_boxes.pop_front();
      if (marker_found !== want.found) report_mismatch("marker_found", marker_found, want.found);
      if (found_color !== want.color) report_mismatch("found_color", found_color, want.color);
      if (left_edge !== want.lft) report_mismatch("left_edge", left_edge, want.lft);
      if (right_edge !== want.rgt) report_mismatch("right_edge", right_edge, want.rgt);
      if (top_edge !== want.tp) report_mismatch("top_edge", top_edge, want.tp);
      if (bottom_edge !== want.btm) report_mismatch("bottom_edge", bottom_edge, want.btm);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tol         = int'(CFG_RESET.tolerance);
      prox        = int'(CFG_RESET.proximity);
      top_rows    = int'(CFG_RESET.top_margin);
      bottom_rows = int'(CFG_RESET.bottom_margin);
      f_width     = int'(CFG_RESET.frame_width);
      f_height    = int'(CFG_RESET.frame_height);
      color_a     = CFG_RESET.primary;
      color_b     = CFG_RESET.secondary;
      clear_boxes();
      expected_boxes.delete();
    end else begin
      if (cfg_write_enable) begin
        case (cfg_reg_t'(cfg_index))
          REG_TOLERANCE:     tol         = int'(cfg_data[TOL_W-1:0]);
          REG_PROXIMITY:     prox        = int'(cfg_data[PROX_W-1:0]);
          REG_TOP_MARGIN:    top_rows    = int'(cfg_data[MARGIN_W-1:0]);
          REG_BOTTOM_MARGIN: bottom_rows = int'(cfg_data[MARGIN_W-1:0]);
          REG_FRAME_WIDTH:   f_width     = int'(cfg_data[DIM_W-1:0]);
          REG_FRAME_HEIGHT:  f_height    = int'(cfg_data[DIM_W-1:0]);
          REG_PRIMARY:       color_a     = cfg_data[COLOR_W-1:0];
          REG_SECONDARY:     color_b     = cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
      // pop before push: a result never belongs to a pixel taken at the same edge
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) track_pixel();
    end
    outstanding <= expected_boxes.size();
  end

endmodule

FILE: test/color_marker_bounding_box_tb.sv
`timescale 1ns / 1ps
// Testbench top for color_marker_bounding_box: drives config and pixel words,
// applies idle/stall patterns and prints the verdict. Depends on cmbb_pkg,
// cmbb_box_checker and the block itself.
module color_marker_bounding_box_tb;
  import cmbb_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no word moving on either channel
  localparam int SETTLE      = 6;     // extra wait after the last result word is back

  logic                   clk;
  logic                   rst              = 1'b1;
  logic                   cfg_write_enable = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index        = '0;
  logic [CFG_DATA_W-1:0]  cfg_data         = '0;
  logic                   in_valid         = 1'b0;
  logic                   in_ready;
  logic [CHAN_W-1:0]      pixel_red        = '0;
  logic [CHAN_W-1:0]      pixel_green      = '0;
  logic [CHAN_W-1:0]      pixel_blue       = '0;
  logic                   first_of_frame   = 1'b0;
  logic                   last_of_frame    = 1'b0;
  logic                   out_valid;
  logic                   out_ready        = 1'b0;
  logic                   marker_found;
  logic                   found_color;
  logic [EDGE_W-1:0]      left_edge;
  logic [EDGE_W-1:0]      right_edge;
  logic [EDGE_W-1:0]      top_edge;
  logic [EDGE_W-1:0]      bottom_edge;
  int                     mismatches;
  int                     outstanding;

  // idling knobs, percent of cycles
  int idle_pct  = 0;
  int stall_pct = 0;
  int phase_no  = 0;
  int pixels_sent = 0;
  int quiet_cycles = 0;

  // copy of what was last written, used to aim pixels near the targets
  int                 cur_tol;
  logic [COLOR_W-1:0] cur_primary, cur_secondary;

  color_marker_bounding_box uut (.*);

  cmbb_box_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver side: ready drops at random according to the current stall rate.
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= stall_pct);

  // Watchdog: any accepted word on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Rotate through the four idling patterns, one per phase.
  task automatic set_idling();
    case (phase_no % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 79; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 79; end
      default: begin idle_pct = 27; stall_pct = 27; end
    endcase
    phase_no++;
  endtask

  // One pixel word. Valid stays up until the handshake completes; the random
  // gap (valid low) only happens before a word, never in the middle of one.
  task automatic send_word(logic [COLOR_W-1:0] rgb, bit first, bit last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    pixel_red      <= rgb[23:16];
    pixel_green    <= rgb[15:8];
    pixel_blue     <= rgb[7:0];
    first_of_frame <= first;
    last_of_frame  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Drop valid and hold off until every result word is back, then give the
  // block time to finish pixels that produce no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all eight registers back to back; caller guarantees the block is idle.
  task automatic configure(int tol, int prox, int top_rows, int bottom_rows, int w, int h,
                           logic [COLOR_W-1:0] pc, logic [COLOR_W-1:0] sc);
    logic [CFG_DATA_W-1:0] vals [8];
    cfg_reg_t reg_id;
    vals[REG_TOLERANCE]     = CFG_DATA_W'(tol);
    vals[REG_PROXIMITY]     = CFG_DATA_W'(prox);
    vals[REG_TOP_MARGIN]    = CFG_DATA_W'(top_rows);
    vals[REG_BOTTOM_MARGIN] = CFG_DATA_W'(bottom_rows);
    vals[REG_FRAME_WIDTH]   = CFG_DATA_W'(w);
    vals[REG_FRAME_HEIGHT]  = CFG_DATA_W'(h);
    vals[REG_PRIMARY]       = pc;
    vals[REG_SECONDARY]     = sc;
    cur_tol       = tol;
    cur_primary   = pc;
    cur_secondary = sc;
    reg_id = reg_id.first();
    repeat (reg_id.num()) begin
      cfg_write_enable <= 1'b1;
      cfg_index        <= reg_id;
      cfg_data         <= vals[reg_id];
      @(posedge clk);
      reg_id = reg_id.next();
    end
    cfg_write_enable <= 1'b0;
  endtask

  // Each channel lands somewhere around the target, straddling the tolerance edge.
  function automatic logic [COLOR_W-1:0] nudge(logic [COLOR_W-1:0] c);
    int spread, v;
    logic [COLOR_W-1:0] shade;
    spread = (cur_tol < 1) ? 1 : (cur_tol > 256 ? 256 : cur_tol);
    for (int i = 0; i < 3; i++) begin
      v = int'(c[8*i +: 8]) + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      shade[8*i +: 8] = v[7:0];
    end
    return shade;
  endfunction

  function automatic logic [COLOR_W-1:0] pick_pixel();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return nudge(cur_primary);
    if (roll < 65) return nudge(cur_secondary);
    return COLOR_W'($urandom());
  endfunction

  task automatic send_pixels(int len, bit first, bit last);
    for (int i = 0; i < len; i++)
      send_word(pick_pixel(), first && i == 0, last && i == len - 1);
  endtask

  // Mostly well-formed frames; some lose the first mark, end early or run long.
  task automatic send_frame(int w, int h);
    int full_len, roll;
    full_len = ((w == 0) ? 1 : w) * h;
    roll = $urandom_range(99);
    if (roll < 80)      send_pixels(full_len, 1'b1, 1'b1);
    else if (roll < 88) send_pixels(full_len, 1'b0, 1'b1);
    else if (roll < 94) send_pixels($urandom_range(1, full_len), 1'b1, 1'b1);
    else                send_pixels(full_len + $urandom_range(1, 8), 1'b1, 1'b1);
  endtask

  task automatic random_phase(int items);
    int tol, prox, w, h, start;
    set_idling();
    case ($urandom_range(9))
      0:       tol = 0;
      1:       tol = 256;
      default: tol = $urandom_range(20, 120);
    endcase
    case ($urandom_range(9))
      0:       prox = 0;
      1:       prox = 1024;
      default: prox = $urandom_range(1, 6);
    endcase
    w = $urandom_range(1, 10);
    h = $urandom_range(1, 8);
    configure(tol, prox, $urandom_range(2), $urandom_range(2), w, h,
              COLOR_W'($urandom()), COLOR_W'($urandom()));
    start = pixels_sent;
    while (pixels_sent - start < items) begin
      send_frame(w, h);
      // occasional full drain with the sender held off
      if ($urandom_range(7) == 0) wait_idle();
    end
    wait_idle();
  endtask

  // Directed 4x4 frame: channel extremes, tolerance boundary (89 hits, 90
  // misses), primary and secondary hits, left edge pulled in and a row halt.
  logic [COLOR_W-1:0] grid [16] = '{
    24'h000000, 24'hFFFFFF, 24'h00FF00, 24'h00FF00,
    24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h00FF00,
    24'h59FF59, 24'h5AFF00, 24'h0000FF, 24'h00FF00,
    24'h00FF00, 24'hFFFF00, 24'h00FFFF, 24'h00FF00
  };

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    set_idling();
    configure(90, 2, 0, 0, 4, 4, 24'h00FF00, 24'h0000FF);
    send_word(24'h808080, 1'b1, 1'b1);   // both marks, no match anywhere
    send_word(24'h0000FF, 1'b1, 1'b1);   // only the secondary color
    for (int i = 0; i < 16; i++)
      send_word(grid[i], i == 0, i == 15);
    // frame keeps going without a first mark; last does not clear the boxes
    send_word(24'h00FF00, 1'b0, 1'b0);
    send_word(24'h0000FF, 1'b0, 1'b1);
    wait_idle();

    // ---- register extremes ----
    // widest row setting, frame cut short, everything matches the white primary
    set_idling();
    configure(256, 1024, 0, 0, 1024, 1, 24'hFFFFFF, 24'h000000);
    send_pixels(100, 1'b1, 1'b1);
    wait_idle();

    // one-pixel rows, tallest frame, run past 1024 rows so the row count wraps
    set_idling();
    configure($urandom_range(40, 100), 1024, 0, 0, 1, 1024, 24'h00FF00, 24'h0000FF);
    send_pixels(1040, 1'b1, 1'b1);
    wait_idle();

    // margins cover the frame, zero tolerance and proximity
    set_idling();
    configure(0, 0, 1023, 1023, 3, 5, 24'h000000, 24'hFFFFFF);
    repeat (3) send_frame(3, 5);
    wait_idle();

    // zero width: every pixel ends a row
    set_idling();
    configure(80, 3, 0, 1, 0, 6, COLOR_W'($urandom()), COLOR_W'($urandom()));
    repeat (4) send_frame(0, 6);
    wait_idle();

    // ---- random part ----
    repeat (4) random_phase(40);

    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
